// ----- hdl/lpht_pkg.sv -----
// shared types, codes and defaults for the linear probe hash table
`default_nettype none

package lpht_pkg;

	localparam int TABLE_SIZE_DEFAULT = 16;
	localparam int KEY_W              = 32;
	localparam int CMD_W              = 2;
	localparam int STATUS_W           = 2;
	localparam int SLOT_W             = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// one table slot as kept in the slot memory
	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
	} slot_entry_t;

endpackage

`default_nettype wire

// ----- hdl/lpht_mod.sv -----
// home slot unit: key modulo table size, constant reciprocal steps for non power of two sizes
`default_nettype none

module lpht_mod #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT,
	parameter int AW         = $clog2(TABLE_SIZE)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lpht_pkg::KEY_W-1:0] key,
	output logic                           done,
	output logic [AW-1:0]                  home
);

	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	generate
		if (IS_POW2) begin : g_pow2
			logic          done_q;
			logic [AW-1:0] home_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			// low bits are the remainder
			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= key[AW-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_recip
			// fold the upper half: hi * (2^16 mod M) + lo keeps the remainder, below 2^26
			localparam int X_W = 26;
			localparam int R_W = 25;
			localparam int P_W = X_W + R_W;
			localparam int B_W = R_W + AW + 1;
			localparam int H_W = 16 + AW;
			localparam logic [AW-1:0]  HI_K    = AW'((1 << 16) % TABLE_SIZE);
			localparam logic [R_W-1:0] RECIP   = R_W'((1 << X_W) / TABLE_SIZE);
			localparam logic [AW:0]    MODULUS = (AW + 1)'(TABLE_SIZE);

			logic           v_s1;
			logic           v_s2;
			logic           v_s3;
			logic           done_q;
			logic [X_W-1:0] x_s1;
			logic [R_W-1:0] quo_s2;
			logic [AW:0]    rem_s3;
			logic [AW-1:0]  home_q;
			logic [H_W-1:0] hi_prod;
			logic [X_W-1:0] x_next;
			logic [P_W-1:0] q_prod;
			logic [B_W-1:0] back_prod;
			logic [X_W-1:0] diff;
			logic [AW:0]    rem_fix;

			// quotient estimate is exact or one low, so one conditional subtract finishes
			always_comb begin
				hi_prod   = H_W'(key[lpht_pkg::KEY_W-1:16]) * H_W'(HI_K);
				x_next    = X_W'(hi_prod) + X_W'(key[15:0]);
				q_prod    = P_W'(x_s1) * P_W'(RECIP);
				back_prod = B_W'(quo_s2) * B_W'(MODULUS);
				diff      = x_s1 - back_prod[X_W-1:0];
				rem_fix   = (rem_s3 >= MODULUS) ? (rem_s3 - MODULUS) : rem_s3;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					v_s3   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					v_s2   <= v_s1;
					v_s3   <= v_s2;
					done_q <= v_s3;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					x_s1 <= x_next;
				end
				if (v_s1) begin
					quo_s2 <= q_prod[P_W-1:X_W];
				end
				if (v_s2) begin
					rem_s3 <= diff[AW:0];
				end
				if (v_s3) begin
					home_q <= rem_fix[AW-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end
	endgenerate

endmodule

`default_nettype wire

// ----- hdl/lpht_mem.sv -----
// slot memory: one write port, one read port with registered data
`default_nettype none

module lpht_mem #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT,
	parameter int AW         = $clog2(TABLE_SIZE)
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire lpht_pkg::slot_entry_t wdata,
	input  wire logic [AW-1:0]         raddr,
	output lpht_pkg::slot_entry_t      rdata
);

	lpht_pkg::slot_entry_t mem [TABLE_SIZE];
	lpht_pkg::slot_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/linear_probe_hash_table.sv -----
// top level: command sequencer for the linear probing hash table
//
// channel   direction  handshake                 payload
// command   in         start & !busy             cmd, key
// result    out        done, one cycle strobe    status, slot
//
// insert and search: the home slot unit finds the home slot (low bits for a power of two
//   table size, constant reciprocal modulo unit otherwise), then 1..TABLE_SIZE
//   probes, one slot read per cycle from the slot memory
// clear sweeps the memory one slot per cycle, then done
// an unused command code answers not found in the cycle after its beat
// after reset the same sweep runs with busy high
// the result strobe cannot be held off; busy is the only back pressure
`default_nettype none

module linear_probe_hash_table #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [lpht_pkg::CMD_W-1:0]    cmd,
	input  wire logic [lpht_pkg::KEY_W-1:0]    key,
	output logic                              done,
	output logic [lpht_pkg::STATUS_W-1:0]      status,
	output logic [lpht_pkg::SLOT_W-1:0]        slot
);

	localparam int AW    = $clog2(TABLE_SIZE);
	localparam int EXT_W = AW + lpht_pkg::SLOT_W;
	localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_SIZE - 1);

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HOME  = 5'b00100,
		S_PROBE = 5'b01000,
		S_CLEAR = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [lpht_pkg::CMD_W-1:0]     cmd_q;
	logic [lpht_pkg::KEY_W-1:0]     key_q;
	logic [AW-1:0]                  home_q;
	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  sweep_q;
	logic                           done_q;
	logic [lpht_pkg::STATUS_W-1:0]  status_q;
	logic [lpht_pkg::SLOT_W-1:0]    slot_q;

	logic                           accept;
	logic                           bad_cmd;
	logic                           mod_start;
	logic                           mod_done;
	logic [AW-1:0]                  mod_home;
	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	lpht_pkg::slot_entry_t          mem_wdata;
	logic [AW-1:0]                  mem_raddr;
	lpht_pkg::slot_entry_t          entry;
	logic [AW-1:0]                  addr_nxt;
	logic                           wrapped;
	logic                           key_hit;
	logic                           probe_end;
	logic [EXT_W-1:0]               addr_ext;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// home slot unit kicks off for insert and search beats
	assign mod_start = accept && ((cmd == lpht_pkg::CMD_INSERT) || (cmd == lpht_pkg::CMD_SEARCH));

	// unused command code, answered without touching the table
	assign bad_cmd = accept &&
		!(cmd inside {lpht_pkg::CMD_INSERT, lpht_pkg::CMD_SEARCH, lpht_pkg::CMD_CLEAR});

	lpht_mod #(
		.TABLE_SIZE(TABLE_SIZE),
		.AW        (AW)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.key   (key),
		.done  (mod_done),
		.home  (mod_home)
	);

	lpht_mem #(
		.TABLE_SIZE(TABLE_SIZE),
		.AW        (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(entry)
	);

	// next probe address wraps from the last slot back to slot 0
	assign addr_nxt = (addr_q == ADDR_LAST) ? '0 : (addr_q + 1'b1);
	// probing the next slot would bring us back home: the whole table was seen
	assign wrapped  = (addr_nxt == home_q);
	assign key_hit  = (entry.key == key_q);
	// insert stops on a free slot, search also on a hit; both stop before home again
	assign probe_end = !entry.used || wrapped || ((cmd_q != lpht_pkg::CMD_INSERT) && key_hit);
	// slot index reported masked to the slot field width
	assign addr_ext = EXT_W'(addr_q);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = addr_q;
		case (state_q)
			S_INIT, S_CLEAR: begin
				// sweep: mark every slot empty
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
			end
			S_HOME: begin
				// read home as soon as it is known
				mem_raddr = mod_home;
			end
			S_PROBE: begin
				// read the following slot while this one is checked
				mem_raddr = addr_nxt;
				if ((cmd_q == lpht_pkg::CMD_INSERT) && !entry.used) begin
					mem_we    = 1'b1;
					mem_wdata = '{used: 1'b1, key: key_q};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					if (sweep_q == ADDR_LAST) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							lpht_pkg::CMD_INSERT, lpht_pkg::CMD_SEARCH: begin
								state_q <= S_HOME;
							end
							lpht_pkg::CMD_CLEAR: begin
								sweep_q <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
								// unused code: answer at once, no state change
							end
						endcase
					end
				end
				S_HOME: begin
					if (mod_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (probe_end) begin
						state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					if (sweep_q == ADDR_LAST) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				default: begin
					sweep_q <= '0;
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// result strobe: end of a probe, end of a clear sweep, or an unused code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= bad_cmd || ((state_q == S_PROBE) && probe_end) ||
				((state_q == S_CLEAR) && (sweep_q == ADDR_LAST));
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			key_q    <= key;
			status_q <= lpht_pkg::ST_MISS;
			slot_q   <= '0;
		end
		if ((state_q == S_HOME) && mod_done) begin
			home_q <= mod_home;
			addr_q <= mod_home;
		end
		case (state_q)
			S_PROBE: begin
				addr_q <= addr_nxt;
				if (cmd_q == lpht_pkg::CMD_INSERT) begin
					if (!entry.used) begin
						status_q <= lpht_pkg::ST_DONE;
						slot_q   <= addr_ext[lpht_pkg::SLOT_W-1:0];
					end else begin
						status_q <= lpht_pkg::ST_FULL;
						slot_q   <= '0;
					end
				end else begin
					if (entry.used && key_hit) begin
						status_q <= lpht_pkg::ST_FOUND;
						slot_q   <= addr_ext[lpht_pkg::SLOT_W-1:0];
					end else begin
						status_q <= lpht_pkg::ST_MISS;
						slot_q   <= '0;
					end
				end
			end
			S_CLEAR: begin
				status_q <= lpht_pkg::ST_DONE;
				slot_q   <= '0;
			end
			default: begin
				// result held until the next beat or probe
			end
		endcase
	end

	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

endmodule

`default_nettype wire

// ----- hdl/lpht_checker.sv -----
// port level checker for the hash table, bound to the top level
`default_nettype none

module lpht_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic [lpht_pkg::CMD_W-1:0]    cmd,
	input wire logic                         done,
	input wire logic [lpht_pkg::STATUS_W-1:0] status,
	input wire logic [lpht_pkg::SLOT_W-1:0]   slot
);

	// insert, search and clear beats make the block busy
	a_work_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((cmd == lpht_pkg::CMD_INSERT) || (cmd == lpht_pkg::CMD_SEARCH)
			|| (cmd == lpht_pkg::CMD_CLEAR))) |=> busy)
		else $error("work beat did not raise busy");

	// an unused command code answers not found in the next cycle
	a_bad_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd != lpht_pkg::CMD_INSERT) && (cmd != lpht_pkg::CMD_SEARCH)
			&& (cmd != lpht_pkg::CMD_CLEAR)) |=> (done && (status == lpht_pkg::ST_MISS)))
		else $error("unused command not answered as a miss");

	// miss and full results carry slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ((status == lpht_pkg::ST_MISS) || (status == lpht_pkg::ST_FULL))) |-> (slot == '0))
		else $error("miss or full result with nonzero slot");

	// a result only follows work in progress or a beat
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a command");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire
